### design/rpd_pkg.sv
package rpd_pkg;

	// Color dither source selection.
	typedef enum logic [1:0] {
		COLOR_MAGIC    = 2'd0,
		COLOR_BAYER    = 2'd1,
		COLOR_NOISE    = 2'd2,
		COLOR_DISABLED = 2'd3
	} color_mode_t;

	// Alpha dither source selection.
	typedef enum logic [1:0] {
		ALPHA_PATTERN  = 2'd0,
		ALPHA_INVERTED = 2'd1,
		ALPHA_NOISE    = 2'd2,
		ALPHA_DISABLED = 2'd3
	} alpha_mode_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_COLOR_MODE  = 2'd0;
	localparam logic [1:0] REG_ALPHA_MODE  = 2'd1;
	localparam logic [1:0] REG_FIELD_SHIFT = 2'd2;
	localparam logic [1:0] REG_NOISE_CYCLE = 2'd3;

	// Dither value used for every channel when color dithering is off.
	localparam logic [2:0] DITHER_OFF_VALUE = 3'd7;

	// Largest channel value that still rounds up without saturating.
	localparam logic [7:0] ROUND_LIMIT = 8'd247;
	localparam logic [7:0] CHANNEL_MAX = 8'd255;

	// Configuration state as seen by the datapath.
	typedef struct packed {
		color_mode_t color_mode;
		alpha_mode_t alpha_mode;
		logic        field_shift;
		logic        noise_cycle;
	} cfg_t;

	// Pixel word held in the input stage; only the coordinate bits that
	// reach the pattern table are kept.
	typedef struct packed {
		logic [1:0] x_lo;
		logic [2:0] y_lo;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] color_random;
		logic [2:0] alpha_noise;
	} pix_t;

	// Result word held in the output stage.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] color_dither;
		logic [2:0] alpha_dither;
	} res_t;

	localparam logic [15:0][2:0] BAYER_TAB = {
		3'd2, 3'd6, 3'd3, 3'd7,
		3'd6, 3'd2, 3'd7, 3'd3,
		3'd1, 3'd5, 3'd0, 3'd4,
		3'd5, 3'd1, 3'd4, 3'd0
	};

	localparam logic [15:0][2:0] MAGIC_TAB = {
		3'd0, 3'd6, 3'd1, 3'd7,
		3'd4, 3'd2, 3'd5, 3'd3,
		3'd3, 3'd5, 3'd2, 3'd4,
		3'd7, 3'd1, 3'd6, 3'd0
	};

	// Pattern entry at a 4-bit table index (row in the upper two bits).
	function automatic logic [2:0] pattern_value(input logic bayer, input logic [3:0] idx);
		pattern_value = bayer ? BAYER_TAB[idx] : MAGIC_TAB[idx];
	endfunction

	// Round a channel up to the next multiple of eight, saturating, when the
	// dither value is below the channel's low three bits.
	function automatic logic [7:0] dither_channel(input logic [7:0] c, input logic [2:0] d);
		logic [7:0] up;
		up = (c > ROUND_LIMIT) ? CHANNEL_MAX : {c[7:3] + 5'd1, 3'b000};
		dither_channel = (d < c[2:0]) ? up : c;
	endfunction

endpackage

### design/rgb_pixel_dither_core.sv
// Ordered and noise dither of one RGB pixel per clock unless out_ready holds
// the output. A pixel word enters an input register, passes through the table
// lookup and rounding logic, and lands in an output register; a new pixel is
// accepted every cycle while the output side keeps taking words, and throughput
// is set by the two-stage pipeline and the output handshake. The held alpha
// noise is loaded from alpha_random as each pixel is accepted when noise
// cycling is enabled, and that same pixel already uses the new value.
// Configuration registers are written through the cfg port (index
// 0 color mode, 1 alpha mode, 2 field shift, 3 noise cycle enable) and should
// be changed only while no pixel is in flight.
module rgb_pixel_dither_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [2:0]  alpha_random,
	input  logic [8:0]  color_random,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [8:0]  color_dither,
	output logic [2:0]  alpha_dither
);

	rpd_pkg::cfg_t cfg;
	rpd_pkg::pix_t pix_s1;
	rpd_pkg::res_t res;
	rpd_pkg::res_t res_s2;
	logic          valid_s1;
	logic          valid_s2;
	logic [2:0]    held_noise_q;
	logic          in_fire;
	logic          adv_s2;

	rpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Pipeline flow control: each stage moves when the next one is free.
	assign adv_s2   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s2;
	assign in_fire  = in_valid && in_ready;

	// Held alpha noise, reloaded on each accepted word when cycling is on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_noise_q <= 3'd0;
		end else if (in_fire && cfg.noise_cycle) begin
			held_noise_q <= alpha_random;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1.x_lo         <= pixel_x[1:0];
			pix_s1.y_lo         <= pixel_y[2:0];
			pix_s1.red          <= red_in;
			pix_s1.green        <= green_in;
			pix_s1.blue         <= blue_in;
			pix_s1.color_random <= color_random;
			pix_s1.alpha_noise  <= cfg.noise_cycle ? alpha_random : held_noise_q;
		end
	end

	rpd_dither u_dither (
		.cfg (cfg),
		.pix (pix_s1),
		.res (res)
	);

	// Output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign red_out      = res_s2.red;
	assign green_out    = res_s2.green;
	assign blue_out     = res_s2.blue;
	assign color_dither = res_s2.color_dither;
	assign alpha_dither = res_s2.alpha_dither;

`ifndef ASSERT_OFF
	// A word leaving the input stage shows up at the output next cycle.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> out_valid)
		else $error("input stage word did not reach output stage");

	// The input stage always takes a word when it is empty.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	// Cycling loads the held noise from the accepted word.
	a_noise_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cfg.noise_cycle) |=> held_noise_q == $past(alpha_random))
		else $error("held alpha noise not loaded");

	// Outside noise mode the color dither value fits in three bits.
	a_cd_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cfg.color_mode != rpd_pkg::COLOR_NOISE) |-> color_dither[8:3] == 6'd0)
		else $error("color dither value too wide");

	// Disabled alpha dithering always yields zero.
	a_alpha_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cfg.alpha_mode == rpd_pkg::ALPHA_DISABLED) |-> alpha_dither == 3'd0)
		else $error("alpha dither nonzero while disabled");
`endif

endmodule

### design/rpd_cfg.sv
module rpd_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [1:0]        cfg_data,
	output rpd_pkg::cfg_t     cfg
);

	rpd_pkg::cfg_t cfg_q;

	// Register writes are always taken; cfg_ready is tied high.
	assign cfg_ready = 1'b1;

	// Register file, written one word per accepted handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_mode  <= rpd_pkg::COLOR_DISABLED;
			cfg_q.alpha_mode  <= rpd_pkg::ALPHA_DISABLED;
			cfg_q.field_shift <= 1'b0;
			cfg_q.noise_cycle <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rpd_pkg::REG_COLOR_MODE:  cfg_q.color_mode  <= rpd_pkg::color_mode_t'(cfg_data);
				rpd_pkg::REG_ALPHA_MODE:  cfg_q.alpha_mode  <= rpd_pkg::alpha_mode_t'(cfg_data);
				rpd_pkg::REG_FIELD_SHIFT: cfg_q.field_shift <= cfg_data[0];
				rpd_pkg::REG_NOISE_CYCLE: cfg_q.noise_cycle <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/rpd_dither.sv
module rpd_dither (
	input  rpd_pkg::cfg_t cfg,
	input  rpd_pkg::pix_t pix,
	output rpd_pkg::res_t res
);

	logic [1:0] row;
	logic [2:0] pat;
	logic [8:0] cd;
	logic [2:0] ad;
	logic [2:0] dr;
	logic [2:0] dg;
	logic [2:0] db;

	// Pattern lookup; the Bayer table is chosen by bit 0 of the color mode,
	// which also serves the alpha pattern modes.
	assign row = cfg.field_shift ? pix.y_lo[2:1] : pix.y_lo[1:0];
	assign pat = rpd_pkg::pattern_value(cfg.color_mode[0], {row, pix.x_lo});

	// Color dither value and its per-channel split.
	always_comb begin
		unique case (cfg.color_mode)
			rpd_pkg::COLOR_MAGIC,
			rpd_pkg::COLOR_BAYER: begin
				cd = {6'd0, pat};
				dr = pat;
				dg = pat;
				db = pat;
			end
			rpd_pkg::COLOR_NOISE: begin
				cd = pix.color_random;
				dr = pix.color_random[2:0];
				dg = pix.color_random[5:3];
				db = pix.color_random[8:6];
			end
			default: begin
				cd = {6'd0, rpd_pkg::DITHER_OFF_VALUE};
				dr = rpd_pkg::DITHER_OFF_VALUE;
				dg = rpd_pkg::DITHER_OFF_VALUE;
				db = rpd_pkg::DITHER_OFF_VALUE;
			end
		endcase
	end

	// Alpha dither value.
	always_comb begin
		unique case (cfg.alpha_mode)
			rpd_pkg::ALPHA_PATTERN:  ad = pat;
			rpd_pkg::ALPHA_INVERTED: ad = ~pat;
			rpd_pkg::ALPHA_NOISE:    ad = pix.alpha_noise;
			default:                 ad = 3'd0;
		endcase
	end

	assign res.red          = rpd_pkg::dither_channel(pix.red, dr);
	assign res.green        = rpd_pkg::dither_channel(pix.green, dg);
	assign res.blue         = rpd_pkg::dither_channel(pix.blue, db);
	assign res.color_dither = cd;
	assign res.alpha_dither = ad;

endmodule
